/* src/tlpdg_pkg.sv */
package tlpdg_pkg;

  typedef enum logic [1:0] {
    REG_POSITION_GAIN  = 2'd0,
    REG_DAMPING_GAIN   = 2'd1,
    REG_GRAVITY_FIRST  = 2'd2,
    REG_GRAVITY_SECOND = 2'd3
  } cfg_reg_t;

  // Pi in Q30.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam int TAYLOR_TERMS = 12;

  // Divisors (2n+1)(2n+2) of the cosine series.
  localparam logic [63:0] TERM_DIV [TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  localparam logic [14:0] COS_ONE = 15'd16384;

  localparam logic signed [35:0] TORQUE_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] TORQUE_MIN = -36'sh0_8000_0000;

endpackage

/* src/two_link_pd_gravity_control_core.sv */
// A result is written to the output register in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the output is not stalled; the cosine lookups, the gain multipliers and
// the saturating adds all sit between the input handshake and the output register.
// A new beat is taken while the output register is empty or its result is being taken in the same cycle.
// Reset is synchronous and active low; it clears the gains, the held references
// and the reference flag, and empties the output register.
module two_link_pd_gravity_control_core #(
  parameter int COS_TABLE_DEPTH = 256,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  tlpdg_pkg::cfg_reg_t  cfg_index,
  input  logic [15:0]          cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_pos_first,
  input  logic signed [15:0]   in_vel_first,
  input  logic signed [15:0]   in_pos_second,
  input  logic signed [15:0]   in_vel_second,
  input  logic                 in_new_ref_valid,
  input  logic signed [15:0]   in_ref_first_in,
  input  logic signed [15:0]   in_ref_second_in,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_torque_first,
  output logic signed [31:0]   out_torque_second,
  output logic                 out_saturated
);
  import tlpdg_pkg::*;

  localparam int          QUAD_SHIFT = ANGLE_BITS - 2;
  localparam int          IDX_W      = $clog2(COS_TABLE_DEPTH + 1);
  localparam logic [63:0] TABLE_DEN  = 64'(2 * COS_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]          DEPTH_IDX = IDX_W'(COS_TABLE_DEPTH);
  localparam logic [QUAD_SHIFT+IDX_W-1:0] DEPTH_MUL = (QUAD_SHIFT + IDX_W)'(COS_TABLE_DEPTH);

  function automatic logic [14:0] cos_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    int                 n;
    x    = (64'(k) * PI_Q30) / TABLE_DEN;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = signed'(term);
    for (n = 0; n < TAYLOR_TERMS; n++) begin
      term = (term * x2) >> 30;
      term = term / TERM_DIV[n];
      if ((n & 1) != 0) begin
        sum = sum + signed'(term);
      end else begin
        sum = sum - signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = (unsigned'(sum) + 64'd32768) >> 16;
    if (rnd > 64'(COS_ONE)) begin
      rnd = 64'(COS_ONE);
    end
    return rnd[14:0];
  endfunction

  logic [14:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos_rom
    localparam logic [14:0] ENTRY = cos_entry(k);
    assign cos_rom[k] = ENTRY;
  end

  logic [15:0] kp_r, kd_r, a1_r, a2_r;
  logic signed [15:0] held_ref_first_r, held_ref_second_r;
  logic        have_ref_r;
  logic        out_valid_r;
  logic signed [31:0] torque_first_r, torque_second_r;
  logic        saturated_r;

  logic        in_fire;
  logic signed [15:0] ref_first, ref_second;
  logic signed [16:0] err_first, err_second;
  logic signed [16:0] angle_sum;
  logic [ANGLE_BITS-1:0] angle [2];
  logic [1:0]            quad [2];
  logic [QUAD_SHIFT+IDX_W-1:0] idx_prod [2];
  logic [IDX_W-1:0]      idx [2];
  logic [IDX_W-1:0]      idx_mir [2];
  logic signed [15:0]    cos_val [2];
  logic signed [32:0]    grav_p1, grav_p2;
  logic signed [33:0]    g1_acc, g2_acc;
  logic signed [33:0]    p_first, p_second, d_first, d_second;
  logic signed [35:0]    t_first, t_second;
  logic signed [31:0]    torque_first_nxt, torque_second_nxt;
  logic                  clip_first, clip_second;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_new_ref_valid) begin
      ref_first  = in_ref_first_in;
      ref_second = in_ref_second_in;
    end else if (have_ref_r) begin
      ref_first  = held_ref_first_r;
      ref_second = held_ref_second_r;
    end else begin
      ref_first  = in_pos_first;
      ref_second = in_pos_second;
    end
    err_first  = 17'(ref_first) - 17'(in_pos_first);
    err_second = 17'(ref_second) - 17'(in_pos_second);
  end

  always_comb begin
    angle_sum = 17'(in_pos_first) + 17'(in_pos_second);
    angle[0]  = ANGLE_BITS'(32'(in_pos_first));
    angle[1]  = ANGLE_BITS'(32'(angle_sum));
    for (int j = 0; j < 2; j++) begin
      quad[j]     = angle[j][ANGLE_BITS-1:ANGLE_BITS-2];
      idx_prod[j] = (QUAD_SHIFT + IDX_W)'(angle[j][QUAD_SHIFT-1:0]) * DEPTH_MUL;
      idx[j]      = idx_prod[j][QUAD_SHIFT +: IDX_W];
      if (idx[j] > DEPTH_IDX) begin
        idx[j] = DEPTH_IDX;
      end
      idx_mir[j] = DEPTH_IDX - idx[j];
      case (quad[j])
        2'd0:    cos_val[j] = signed'({1'b0, cos_rom[idx[j]]});
        2'd1:    cos_val[j] = -signed'({1'b0, cos_rom[idx_mir[j]]});
        2'd2:    cos_val[j] = -signed'({1'b0, cos_rom[idx[j]]});
        default: cos_val[j] = signed'({1'b0, cos_rom[idx_mir[j]]});
      endcase
    end
  end

  always_comb begin
    grav_p1 = signed'({1'b0, a1_r}) * cos_val[0];
    grav_p2 = signed'({1'b0, a2_r}) * cos_val[1];
    g1_acc  = 34'(grav_p1) + 34'(grav_p2) + 34'sd8192;
    g2_acc  = 34'(grav_p2) + 34'sd8192;

    p_first  = signed'({1'b0, kp_r}) * err_first;
    p_second = signed'({1'b0, kp_r}) * err_second;
    d_first  = signed'({1'b0, kd_r}) * 17'(in_vel_first);
    d_second = signed'({1'b0, kd_r}) * 17'(in_vel_second);

    t_first  = 36'(g1_acc >>> 14) + 36'(p_first) - 36'(d_first);
    t_second = 36'(g2_acc >>> 14) + 36'(p_second) - 36'(d_second);

    clip_first  = (t_first > TORQUE_MAX) || (t_first < TORQUE_MIN);
    clip_second = (t_second > TORQUE_MAX) || (t_second < TORQUE_MIN);

    if (t_first > TORQUE_MAX) begin
      torque_first_nxt = TORQUE_MAX[31:0];
    end else if (t_first < TORQUE_MIN) begin
      torque_first_nxt = TORQUE_MIN[31:0];
    end else begin
      torque_first_nxt = t_first[31:0];
    end
    if (t_second > TORQUE_MAX) begin
      torque_second_nxt = TORQUE_MAX[31:0];
    end else if (t_second < TORQUE_MIN) begin
      torque_second_nxt = TORQUE_MIN[31:0];
    end else begin
      torque_second_nxt = t_second[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0;
      kd_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSITION_GAIN:  kp_r <= cfg_wdata;
        REG_DAMPING_GAIN:   kd_r <= cfg_wdata;
        REG_GRAVITY_FIRST:  a1_r <= cfg_wdata;
        REG_GRAVITY_SECOND: a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r        <= 1'b0;
      held_ref_first_r  <= '0;
      held_ref_second_r <= '0;
    end else if (in_fire && in_new_ref_valid) begin
      have_ref_r        <= 1'b1;
      held_ref_first_r  <= in_ref_first_in;
      held_ref_second_r <= in_ref_second_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      torque_first_r  <= torque_first_nxt;
      torque_second_r <= torque_second_nxt;
      saturated_r     <= clip_first || clip_second;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_torque_first  = torque_first_r;
  assign out_torque_second = torque_second_r;
  assign out_saturated     = saturated_r;

`ifndef SYNTHESIS
  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("Accepted beat did not reach the output register.");

  a_ref_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_ref_r |=> have_ref_r)
    else $error("Reference flag dropped without reset.");

  a_ref_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_new_ref_valid |=> held_ref_first_r == $past(in_ref_first_in) &&
      held_ref_second_r == $past(in_ref_second_in))
    else $error("New reference pair was not stored.");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && saturated_r |->
      torque_first_r == TORQUE_MAX[31:0] || torque_first_r == TORQUE_MIN[31:0] ||
      torque_second_r == TORQUE_MAX[31:0] || torque_second_r == TORQUE_MIN[31:0])
    else $error("Saturation flag set with no torque at a rail.");
`endif

endmodule

/* tb/sv/tlpdg_torque_checker.sv */
module tlpdg_torque_checker (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  tlpdg_pkg::cfg_reg_t  cfg_index,
  input  logic [15:0]          cfg_wdata,

  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [15:0]   in_pos_first,
  input  logic signed [15:0]   in_vel_first,
  input  logic signed [15:0]   in_pos_second,
  input  logic signed [15:0]   in_vel_second,
  input  logic                 in_new_ref_valid,
  input  logic signed [15:0]   in_ref_first_in,
  input  logic signed [15:0]   in_ref_second_in,

  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [31:0]   out_torque_first,
  input  logic signed [31:0]   out_torque_second,
  input  logic                 out_saturated,

  output int                   mismatches,
  output int                   pending,
  output int                   clipped_results
);

  timeunit 1ns;
  timeprecision 1ps;

  import tlpdg_pkg::*;

  localparam int LUT_DEPTH = 256;
  localparam int SERIES_TERMS = 12;
  localparam longint unsigned PI_FIXED = 64'd3373259426;
  localparam longint TORQUE_HI = 64'sd2147483647;
  localparam longint TORQUE_LO = -64'sd2147483648;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [31:0] tq_first;
    logic signed [31:0] tq_second;
    logic               sat;
  } torque_pair_t;

  torque_pair_t expected_torques [$];

  logic [15:0]        kp;
  logic [15:0]        kd;
  logic [15:0]        grav_a1;
  logic [15:0]        grav_a2;
  logic signed [15:0] held_first;
  logic signed [15:0] held_second;
  logic               ref_known;
  int                 cos_lut [0:LUT_DEPTH];

  initial begin
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint acc;
    for (int k = 0; k <= LUT_DEPTH; k++) begin
      x = (u64_t'(k) * PI_FIXED) / u64_t'(2 * LUT_DEPTH);
      x2 = (x * x) >> 30;
      term = u64_t'(1) << 30;
      acc = longint'(term);
      for (int n = 0; n < SERIES_TERMS; n++) begin
        term = (term * x2) >> 30;
        term = term / u64_t'((2 * n + 1) * (2 * n + 2));
        if (n % 2 == 1) begin
          acc = acc + longint'(term);
        end else begin
          acc = acc - longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = longint'((u64_t'(acc) + u64_t'(32768)) >> 16);
      if (acc > 16384) begin
        acc = 16384;
      end
      cos_lut[k] = int'(acc);
    end
  end

  function automatic longint cos_lookup(input logic [15:0] ang);
    int idx;
    idx = (int'(ang[13:0]) * LUT_DEPTH) >> 14;
    if (idx > LUT_DEPTH) begin
      idx = LUT_DEPTH;
    end
    case (ang[15:14])
      2'b00:   return longint'(cos_lut[idx]);
      2'b01:   return -longint'(cos_lut[LUT_DEPTH - idx]);
      2'b10:   return -longint'(cos_lut[idx]);
      default: return longint'(cos_lut[LUT_DEPTH - idx]);
    endcase
  endfunction

  function automatic torque_pair_t compute_torques(
    input logic signed [15:0] q1,
    input logic signed [15:0] v1,
    input logic signed [15:0] q2,
    input logic signed [15:0] v2,
    input logic signed [15:0] r1,
    input logic signed [15:0] r2
  );
    logic [15:0]  ang_sum;
    longint       c1;
    longint       c12;
    longint       g1;
    longint       g2;
    longint       t1;
    longint       t2;
    torque_pair_t res;
    ang_sum = q1 + q2;
    c1 = cos_lookup(q1);
    c12 = cos_lookup(ang_sum);
    g1 = (longint'(grav_a1) * c1 + longint'(grav_a2) * c12 + 64'sd8192) >>> 14;
    g2 = (longint'(grav_a2) * c12 + 64'sd8192) >>> 14;
    t1 = g1 + longint'(kp) * (longint'(r1) - longint'(q1)) - longint'(kd) * longint'(v1);
    t2 = g2 + longint'(kp) * (longint'(r2) - longint'(q2)) - longint'(kd) * longint'(v2);
    res.sat = 1'b0;
    if (t1 > TORQUE_HI || t1 < TORQUE_LO) begin
      res.sat = 1'b1;
      t1 = (t1 > TORQUE_HI) ? TORQUE_HI : TORQUE_LO;
    end
    if (t2 > TORQUE_HI || t2 < TORQUE_LO) begin
      res.sat = 1'b1;
      t2 = (t2 > TORQUE_HI) ? TORQUE_HI : TORQUE_LO;
    end
    res.tq_first = t1[31:0];
    res.tq_second = t2[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    torque_pair_t want;
    if (!rst_n) begin
      kp = '0;
      kd = '0;
      grav_a1 = '0;
      grav_a2 = '0;
      held_first = '0;
      held_second = '0;
      ref_known = 1'b0;
      mismatches = 0;
      clipped_results = 0;
      expected_torques.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POSITION_GAIN:  kp = cfg_wdata;
          REG_DAMPING_GAIN:   kd = cfg_wdata;
          REG_GRAVITY_FIRST:  grav_a1 = cfg_wdata;
          REG_GRAVITY_SECOND: grav_a2 = cfg_wdata;
          default: ;
        endcase
      end
      // A result beat always belongs to a tick taken on an earlier edge.
      if (out_valid && out_ready) begin
        if (expected_torques.size() == 0) begin
          $error("torque beat with no tick outstanding: %0d %0d %0b",
                 out_torque_first, out_torque_second, out_saturated);
          mismatches++;
        end else begin
          want = expected_torques.pop_front();
          if (out_torque_first !== want.tq_first) begin
            $error("torque_first: expected %0d, got %0d", want.tq_first, out_torque_first);
            mismatches++;
          end
          if (out_torque_second !== want.tq_second) begin
            $error("torque_second: expected %0d, got %0d", want.tq_second, out_torque_second);
            mismatches++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
            mismatches++;
          end
          if (want.sat) begin
            clipped_results++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_new_ref_valid) begin
          held_first = in_ref_first_in;
          held_second = in_ref_second_in;
          ref_known = 1'b1;
        end
        expected_torques = {expected_torques, compute_torques(
          in_pos_first, in_vel_first, in_pos_second, in_vel_second,
          ref_known ? held_first : in_pos_first,
          ref_known ? held_second : in_pos_second)};
      end
    end
    pending = expected_torques.size();
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tlpdg_pkg::*;

  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 157;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [15:0] pos1;
    logic signed [15:0] vel1;
    logic signed [15:0] pos2;
    logic signed [15:0] vel2;
    logic               new_ref;
    logic signed [15:0] ref1;
    logic signed [15:0] ref2;
  } joint_tick_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_reg_t           cfg_index = REG_POSITION_GAIN;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_pos_first = '0;
  logic signed [15:0] in_vel_first = '0;
  logic signed [15:0] in_pos_second = '0;
  logic signed [15:0] in_vel_second = '0;
  logic               in_new_ref_valid = 1'b0;
  logic signed [15:0] in_ref_first_in = '0;
  logic signed [15:0] in_ref_second_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_torque_first;
  logic signed [31:0] out_torque_second;
  logic               out_saturated;

  int mismatches;
  int pending;
  int clipped_results;
  bit steady = 1'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;
  int tick_count = 0;
  int ref_count = 0;
  int setting_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  two_link_pd_gravity_control_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_first     (in_pos_first),
    .in_vel_first     (in_vel_first),
    .in_pos_second    (in_pos_second),
    .in_vel_second    (in_vel_second),
    .in_new_ref_valid (in_new_ref_valid),
    .in_ref_first_in  (in_ref_first_in),
    .in_ref_second_in (in_ref_second_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_torque_first (out_torque_first),
    .out_torque_second(out_torque_second),
    .out_saturated    (out_saturated)
  );

  tlpdg_torque_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_first     (in_pos_first),
    .in_vel_first     (in_vel_first),
    .in_pos_second    (in_pos_second),
    .in_vel_second    (in_vel_second),
    .in_new_ref_valid (in_new_ref_valid),
    .in_ref_first_in  (in_ref_first_in),
    .in_ref_second_in (in_ref_second_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_torque_first (out_torque_first),
    .out_torque_second(out_torque_second),
    .out_saturated    (out_saturated),
    .mismatches       (mismatches),
    .pending          (pending),
    .clipped_results  (clipped_results)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] pick_value();
    logic [15:0] corners [8];
    corners = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    if ($urandom_range(0, 9) == 0) begin
      return corners[$urandom_range(0, 7)];
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 16'h03FF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic joint_tick_t make_tick(
    input logic [15:0] p1, v1, p2, v2,
    input logic        nr,
    input logic [15:0] r1, r2
  );
    joint_tick_t t;
    t.pos1 = p1;
    t.vel1 = v1;
    t.pos2 = p2;
    t.vel2 = v2;
    t.new_ref = nr;
    t.ref1 = r1;
    t.ref2 = r2;
    return t;
  endfunction

  // Stalls on the result side: stay ready for a while, then maybe pause.
  always @(posedge clk) begin
    int stall;
    stall = pick_gap();
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_ready || stall == 0) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b0;
      ready_hold <= stall - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input joint_tick_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_first <= t.pos1;
    in_vel_first <= t.vel1;
    in_pos_second <= t.pos2;
    in_vel_second <= t.vel2;
    in_new_ref_valid <= t.new_ref;
    in_ref_first_in <= t.ref1;
    in_ref_second_in <= t.ref2;
    do @(posedge clk); while (!in_ready);
    tick_count++;
    if (t.new_ref) begin
      ref_count++;
    end
  endtask

  // Stop sending and let every outstanding torque beat drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_gains(input logic [15:0] kp, kd, a1, a2);
    logic [15:0] vals [4];
    cfg_reg_t    r;
    vals = '{kp, kd, a1, a2};
    r = r.first();
    for (int i = 0; i < r.num(); i++) begin
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= vals[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(make_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'hFFFF, 16'hFFFF));
    settle();

    load_gains(16'h0100, 16'h0040, 16'h2000, 16'h1000);
    send_tick(make_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h7FFF, 16'h8000));
    send_tick(make_tick(16'h4000, 16'd100, 16'h0000, -16'sd100, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hC000, 16'hFFFF, 16'h4000, 16'h0001, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h3FFF, 16'h0000, 16'h3FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hBFFF, 16'd5, 16'h0040, -16'sd5, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h7FFF, 16'h8000));
    send_tick(make_tick(16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'h1234, 16'h1234));
    send_tick(make_tick(16'd12345, -16'sd200, -16'sd5000, 16'd300, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'd100, 16'h0000, 16'd200, 16'h0000, 1'b1, 16'h8000, 16'h7FFF));
    send_tick(make_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'd500, 16'h0000, -16'sd500, 16'h0000, 1'b1, 16'd500, -16'sd500));
    settle();

    load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(make_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000));
    send_tick(make_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h7FFF, 16'h8000));
    send_tick(make_tick(16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000));
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 1) begin
        load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end else begin
        load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      end
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        send_tick(make_tick(pick_value(), pick_value(), pick_value(), pick_value(),
                            $urandom_range(0, 7) == 0, pick_value(), pick_value()));
      end
      settle();
    end

    $display("Sent %0d control ticks under %0d gain settings, %0d with a new reference.",
             tick_count, setting_count, ref_count);
    $display("%0d torque results were clipped to the 32-bit range.", clipped_results);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
